// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/mrji_pkg.sv
// ----------------------------------------------------------------------------
// mrji_pkg
// Types, constants and helpers shared by the jog integrator modules.
// ----------------------------------------------------------------------------
package mrji_pkg;

  // Field widths
  localparam int unsigned POS_W   = 32;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned ACT_W   = 4;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 3;

  // Shared multiplier: signed A by signed B
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = DT_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Step scaling: Q9.39 down to Q16.16, and Q8.24 down to Q16.16
  localparam int unsigned XY_SHIFT  = 23;
  localparam int unsigned DIR_SHIFT = 8;
  localparam int unsigned XY_STEP_W = PROD_W - XY_SHIFT;
  localparam int unsigned DIR_STEP_W = PROD_W - DIR_SHIFT;
  localparam int unsigned SUM_W     = 44;

  // Default parameter values
  localparam int unsigned Z_TURN_SPEED_DEF = 256;
  localparam int unsigned D_MOVE_SPEED_DEF = 256;
  localparam int unsigned BRANCH_SPEED_DEF = 256;
  localparam int unsigned DEAD_ZONE_DEF    = 1;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Configuration reset values
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0]      SPEED_ONE = 16'd256;

  // Input action codes
  typedef enum logic [ACT_W-1:0] {
    OP_X_RATE   = 4'd0,
    OP_Y_RATE   = 4'd1,
    OP_Z_LEFT   = 4'd2,
    OP_Z_RIGHT  = 4'd3,
    OP_D_PUSH   = 4'd4,
    OP_D_PULL   = 4'd5,
    OP_BR_APART = 4'd6,
    OP_BR_TOGETHER = 4'd7,
    OP_TICK     = 4'd8
  } op_t;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_X_LOW   = 3'd0,
    REG_X_HIGH  = 3'd1,
    REG_Y_LOW   = 3'd2,
    REG_Y_HIGH  = 3'd3,
    REG_D_LOW   = 3'd4,
    REG_D_HIGH  = 3'd5,
    REG_X_SPEED = 3'd6,
    REG_Y_SPEED = 3'd7
  } reg_idx_t;

  // Direction codes
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_SPARE = 2'd2,
    DIR_MINUS = 2'd3
  } dir_t;

  // One queued item
  typedef struct packed {
    op_t                       op;
    logic signed [RATE_W-1:0]  rate;
    logic [DT_W-1:0]           dt;
  } item_t;

  // Queue status towards the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back status towards the top level
  typedef struct packed {
    logic idle;
    logic pop;
    logic finishing;
  } back_stat_t;

  // Signed multiplier operand for a direction axis: +speed, -speed or zero
  function automatic logic signed [MUL_A_W-1:0] dir_operand(
    input dir_t dir, input logic [SPEED_W-1:0] speed);
    logic signed [MUL_A_W-1:0] mag;
    mag = MUL_A_W'(speed);
    if (dir == DIR_PLUS) begin
      return mag;
    end else if (dir == DIR_MINUS) begin
      return -mag;
    end
    return '0;
  endfunction

  // Saturate a wide sum to the 32-bit signed range
  function automatic logic signed [POS_W-1:0] sat_pos(
    input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(POS_MAX)) begin
      return POS_MAX;
    end else if (v < SUM_W'(POS_MIN)) begin
      return POS_MIN;
    end
    return v[POS_W-1:0];
  endfunction

  // Clamp to bounds, low first so a crossed pair ends on the high bound
  function automatic logic signed [POS_W-1:0] clamp_pos(
    input logic signed [POS_W-1:0] v,
    input logic signed [POS_W-1:0] lo,
    input logic signed [POS_W-1:0] hi);
    logic signed [POS_W-1:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

// File: src/mrji_front.sv
// ----------------------------------------------------------------------------
// mrji_front
// Input side: accepts items, decodes the action and drops unused codes.
// ----------------------------------------------------------------------------
module mrji_front (
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [mrji_pkg::ACT_W-1:0]            action,
  input  logic signed [mrji_pkg::RATE_W-1:0]    rate_value,
  input  logic [mrji_pkg::DT_W-1:0]             tick_length,
  input  logic                                  q_full,
  output logic                                  push,
  output mrji_pkg::item_t                       push_item
);

  logic known;

  // Accept whenever the queue has room
  assign in_ready = !q_full;

  // Codes above tick mean nothing: take the item, queue nothing
  assign known = (action <= mrji_pkg::ACT_W'(mrji_pkg::OP_TICK));
  assign push  = in_valid && in_ready && known;

  // Pack the decoded item
  always_comb begin
    push_item.op   = mrji_pkg::op_t'(action);
    push_item.rate = rate_value;
    push_item.dt   = tick_length;
  end

endmodule

// File: src/mrji_queue.sv
// ----------------------------------------------------------------------------
// mrji_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module mrji_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mrji_pkg::item_t      push_item,
  input  logic                 pop,
  output mrji_pkg::item_t      head,
  output mrji_pkg::q_stat_t    stat
);

  localparam int unsigned DEPTH = mrji_pkg::Q_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mrji_pkg::item_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  // Store incoming items
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/mrji_back.sv
// ----------------------------------------------------------------------------
// mrji_back
// Execution side: holds axis state and registers, runs ticks through one
// shared multiplier and presents the positions in an output register.
// ----------------------------------------------------------------------------
module mrji_back #(
  parameter int unsigned Z_TURN_SPEED = mrji_pkg::Z_TURN_SPEED_DEF,
  parameter int unsigned D_MOVE_SPEED = mrji_pkg::D_MOVE_SPEED_DEF,
  parameter int unsigned BRANCH_SPEED = mrji_pkg::BRANCH_SPEED_DEF,
  parameter int unsigned DEAD_ZONE    = mrji_pkg::DEAD_ZONE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mrji_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [mrji_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 q_empty,
  input  mrji_pkg::item_t                      head,
  output mrji_pkg::back_stat_t                 stat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mrji_pkg::POS_W-1:0]    x_position,
  output logic signed [mrji_pkg::POS_W-1:0]    y_position,
  output logic signed [mrji_pkg::POS_W-1:0]    z_rotation,
  output logic signed [mrji_pkg::POS_W-1:0]    d_position,
  output logic signed [mrji_pkg::POS_W-1:0]    branch_angle
);

  localparam int unsigned POS_W  = mrji_pkg::POS_W;
  localparam int unsigned A_W    = mrji_pkg::MUL_A_W;
  localparam int unsigned B_W    = mrji_pkg::MUL_B_W;
  localparam int unsigned P_W    = mrji_pkg::PROD_W;
  localparam int unsigned XS_W   = mrji_pkg::XY_STEP_W;
  localparam int unsigned DS_W   = mrji_pkg::DIR_STEP_W;
  localparam int unsigned SUM_W  = mrji_pkg::SUM_W;
  localparam int unsigned SPD_W  = mrji_pkg::SPEED_W;
  localparam logic signed [XS_W:0] DZ = (XS_W + 1)'(DEAD_ZONE);

  // Tick sequencer
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_XR    = 10'b00_0000_0010,
    S_XD    = 10'b00_0000_0100,
    S_YR    = 10'b00_0000_1000,
    S_YD    = 10'b00_0001_0000,
    S_Z     = 10'b00_0010_0000,
    S_D     = 10'b00_0100_0000,
    S_B     = 10'b00_1000_0000,
    S_FIN   = 10'b01_0000_0000,
    S_CLAMP = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic signed [POS_W-1:0] x_low_bound, x_high_bound;
  logic signed [POS_W-1:0] y_low_bound, y_high_bound;
  logic signed [POS_W-1:0] d_low_bound, d_high_bound;
  logic [SPD_W-1:0]        x_speed, y_speed;

  // Axis state
  logic signed [mrji_pkg::RATE_W-1:0] x_rate, y_rate;
  mrji_pkg::dir_t                     z_direction, d_direction, branch_direction;
  logic signed [POS_W-1:0]            x_pos, y_pos, z_pos, d_pos, branch_pos;
  logic [mrji_pkg::DT_W-1:0]          dt;

  // Multiplier path
  logic signed [A_W-1:0]  mul_a;
  logic signed [B_W-1:0]  mul_b;
  logic signed [P_W-1:0]  prod;
  logic signed [P_W-1:0]  pr;

  // Step and update logic
  logic signed [XS_W-1:0]  xy_step;
  logic signed [DS_W-1:0]  dir_step;
  logic                    dz_pass;
  logic signed [POS_W-1:0] x_new, y_new, d_new;
  logic signed [POS_W-1:0] x_clamped, y_clamped, d_clamped;
  logic                    out_free;
  logic                    pop;

  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || out_ready;

  assign stat.idle      = (state == S_IDLE);
  assign stat.pop       = pop;
  assign stat.finishing = (state == S_CLAMP);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low_bound  <= mrji_pkg::POS_MIN;
      x_high_bound <= mrji_pkg::POS_MAX;
      y_low_bound  <= mrji_pkg::POS_MIN;
      y_high_bound <= mrji_pkg::POS_MAX;
      d_low_bound  <= mrji_pkg::POS_MIN;
      d_high_bound <= mrji_pkg::POS_MAX;
      x_speed      <= mrji_pkg::SPEED_ONE;
      y_speed      <= mrji_pkg::SPEED_ONE;
    end else if (cfg_write) begin
      unique case (mrji_pkg::reg_idx_t'(cfg_index))
        mrji_pkg::REG_X_LOW:   x_low_bound  <= cfg_data[POS_W-1:0];
        mrji_pkg::REG_X_HIGH:  x_high_bound <= cfg_data[POS_W-1:0];
        mrji_pkg::REG_Y_LOW:   y_low_bound  <= cfg_data[POS_W-1:0];
        mrji_pkg::REG_Y_HIGH:  y_high_bound <= cfg_data[POS_W-1:0];
        mrji_pkg::REG_D_LOW:   d_low_bound  <= cfg_data[POS_W-1:0];
        mrji_pkg::REG_D_HIGH:  d_high_bound <= cfg_data[POS_W-1:0];
        mrji_pkg::REG_X_SPEED: x_speed      <= cfg_data[SPD_W-1:0];
        mrji_pkg::REG_Y_SPEED: y_speed      <= cfg_data[SPD_W-1:0];
      endcase
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_XR: begin
        mul_a = A_W'(x_rate);
        mul_b = B_W'(x_speed);
      end
      S_XD, S_YD: begin
        mul_a = pr[A_W-1:0];
        mul_b = B_W'(dt);
      end
      S_YR: begin
        mul_a = A_W'(y_rate);
        mul_b = B_W'(y_speed);
      end
      S_Z: begin
        mul_a = mrji_pkg::dir_operand(z_direction, SPD_W'(Z_TURN_SPEED));
        mul_b = B_W'(dt);
      end
      S_D: begin
        mul_a = mrji_pkg::dir_operand(d_direction, SPD_W'(D_MOVE_SPEED));
        mul_b = B_W'(dt);
      end
      S_B: begin
        mul_a = mrji_pkg::dir_operand(branch_direction, SPD_W'(BRANCH_SPEED));
        mul_b = B_W'(dt);
      end
      S_IDLE, S_FIN, S_CLAMP: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Register the product
  always_ff @(posedge clk) begin
    pr <= prod;
  end

  // Floor shifts are the upper product bits
  assign xy_step  = pr[P_W-1:mrji_pkg::XY_SHIFT];
  assign dir_step = pr[P_W-1:mrji_pkg::DIR_SHIFT];
  assign dz_pass  = ((XS_W + 1)'(xy_step) > DZ) || ((XS_W + 1)'(xy_step) < -DZ);

  assign x_new = mrji_pkg::sat_pos(SUM_W'(x_pos) + SUM_W'(xy_step));
  assign y_new = mrji_pkg::sat_pos(SUM_W'(y_pos) - SUM_W'(xy_step));
  assign d_new = mrji_pkg::sat_pos(SUM_W'(d_pos) + SUM_W'(dir_step));

  assign x_clamped = mrji_pkg::clamp_pos(x_pos, x_low_bound, x_high_bound);
  assign y_clamped = mrji_pkg::clamp_pos(y_pos, y_low_bound, y_high_bound);
  assign d_clamped = mrji_pkg::clamp_pos(d_pos, d_low_bound, d_high_bound);

  // Advance the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (pop && head.op == mrji_pkg::OP_TICK) state_next = S_XR;
      S_XR:    state_next = S_XD;
      S_XD:    state_next = S_YR;
      S_YR:    state_next = S_YD;
      S_YD:    state_next = S_Z;
      S_Z:     state_next = S_D;
      S_D:     state_next = S_B;
      S_B:     state_next = S_FIN;
      S_FIN:   state_next = S_CLAMP;
      S_CLAMP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Apply events and tick steps to the axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      x_rate           <= '0;
      y_rate           <= '0;
      z_direction      <= mrji_pkg::DIR_NONE;
      d_direction      <= mrji_pkg::DIR_NONE;
      branch_direction <= mrji_pkg::DIR_NONE;
      x_pos            <= '0;
      y_pos            <= '0;
      z_pos            <= '0;
      d_pos            <= '0;
      branch_pos       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (head.op)
              mrji_pkg::OP_X_RATE:      x_rate <= head.rate;
              mrji_pkg::OP_Y_RATE:      y_rate <= head.rate;
              mrji_pkg::OP_Z_LEFT:      z_direction <= mrji_pkg::DIR_MINUS;
              mrji_pkg::OP_Z_RIGHT:     z_direction <= mrji_pkg::DIR_PLUS;
              mrji_pkg::OP_D_PUSH:      d_direction <= mrji_pkg::DIR_PLUS;
              mrji_pkg::OP_D_PULL:      d_direction <= mrji_pkg::DIR_MINUS;
              mrji_pkg::OP_BR_APART:    branch_direction <= mrji_pkg::DIR_PLUS;
              mrji_pkg::OP_BR_TOGETHER: branch_direction <= mrji_pkg::DIR_MINUS;
              mrji_pkg::OP_TICK:        ;
              default:                  ;
            endcase
          end
        end
        S_YR:  if (dz_pass) x_pos <= x_new;
        S_Z:   if (dz_pass) y_pos <= y_new;
        S_D:   z_pos <= z_pos + dir_step[POS_W-1:0];
        S_B:   d_pos <= d_new;
        S_FIN: branch_pos <= branch_pos + dir_step[POS_W-1:0];
        S_CLAMP: begin
          if (out_free) begin
            x_pos       <= x_clamped;
            y_pos       <= y_clamped;
            d_pos       <= d_clamped;
            z_direction <= mrji_pkg::DIR_NONE;
            d_direction <= mrji_pkg::DIR_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the tick length for the sequence
  always_ff @(posedge clk) begin
    if (pop && head.op == mrji_pkg::OP_TICK) begin
      dt <= head.dt;
    end
  end

  // Output register: load on the final step, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_CLAMP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLAMP && out_free) begin
      x_position   <= x_clamped;
      y_position   <= y_clamped;
      z_rotation   <= z_pos;
      d_position   <= d_clamped;
      branch_angle <= branch_pos;
    end
  end

endmodule

// File: src/multi_axis_rate_jog_integrator.sv
// ----------------------------------------------------------------------------
// multi_axis_rate_jog_integrator
// Rate-mode jog integrator for five axes with clamped and wrapping positions.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid / in_ready     action, rate_value, tick_length
//  out       out_valid / out_ready   x_position .. branch_angle
//  cfg       cfg_write               cfg_index, cfg_data
//
//  Front takes one item per cycle while the two-entry queue has room.
//  An event is applied in the back as it is popped; a tick runs seven
//  passes through the single shared multiplier, then apply and clamp.
//  A tick waits in its last step while the output register is still held.
//  Reset is synchronous; it restores bounds, speeds and zeroes all axes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_axis_rate_jog_integrator #(
  parameter int unsigned Z_TURN_SPEED = mrji_pkg::Z_TURN_SPEED_DEF,
  parameter int unsigned D_MOVE_SPEED = mrji_pkg::D_MOVE_SPEED_DEF,
  parameter int unsigned BRANCH_SPEED = mrji_pkg::BRANCH_SPEED_DEF,
  parameter int unsigned DEAD_ZONE    = mrji_pkg::DEAD_ZONE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mrji_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [mrji_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mrji_pkg::ACT_W-1:0]           action,
  input  logic signed [mrji_pkg::RATE_W-1:0]   rate_value,
  input  logic [mrji_pkg::DT_W-1:0]            tick_length,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mrji_pkg::POS_W-1:0]    x_position,
  output logic signed [mrji_pkg::POS_W-1:0]    y_position,
  output logic signed [mrji_pkg::POS_W-1:0]    z_rotation,
  output logic signed [mrji_pkg::POS_W-1:0]    d_position,
  output logic signed [mrji_pkg::POS_W-1:0]    branch_angle
);

  logic                  push;
  mrji_pkg::item_t       push_item;
  mrji_pkg::item_t       head;
  mrji_pkg::q_stat_t     q_stat;
  mrji_pkg::back_stat_t  b_stat;

  // Decode and accept
  mrji_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .rate_value  (rate_value),
    .tick_length (tick_length),
    .q_full      (q_stat.full),
    .push        (push),
    .push_item   (push_item)
  );

  // Decouple front from back
  mrji_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (b_stat.pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Execute events and ticks
  mrji_back #(
    .Z_TURN_SPEED (Z_TURN_SPEED),
    .D_MOVE_SPEED (D_MOVE_SPEED),
    .BRANCH_SPEED (BRANCH_SPEED),
    .DEAD_ZONE    (DEAD_ZONE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_empty      (q_stat.empty),
    .head         (head),
    .stat         (b_stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .x_position   (x_position),
    .y_position   (y_position),
    .z_rotation   (z_rotation),
    .d_position   (d_position),
    .branch_angle (branch_angle)
  );

  // Queue count is consistent
  `ASSERT_ALWAYS(a_queue_state, !(q_stat.full && q_stat.empty), "queue full and empty")
  // Back never takes from an empty queue
  `ASSERT_IMPLIES(a_pop_nonempty, b_stat.pop, !q_stat.empty, "pop from empty queue")
  // Back takes a new item only between ticks
  `ASSERT_IMPLIES(a_pop_idle, b_stat.pop, b_stat.idle, "pop while busy")
  // A result appears only after the final tick step
  `ASSERT_IMPLIES(a_out_after_tick, $rose(out_valid), $past(b_stat.finishing), "stray result")

endmodule
